// ===== hw/rtl/rctn_pkg.sv =====
// ----------------------------------------------------------------------------
// rctn_pkg
// Shared types, sizes and codes for the row convolution, transpose and
// normalization block.
// ----------------------------------------------------------------------------
package rctn_pkg;

    // Largest image and kernel the storage is built for.
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_RADIUS = 31;

    // Derived storage sizes.
    localparam int TAP_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int TAP_AW    = $clog2(TAP_DEPTH);
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int X_W       = $clog2(MAX_WIDTH);
    localparam int Y_W       = $clog2(MAX_HEIGHT);
    localparam int EW_W      = $clog2(MAX_WIDTH + 1);
    localparam int EH_W      = $clog2(MAX_HEIGHT + 1);
    localparam int R_W       = $clog2(MAX_RADIUS + 1);
    localparam int TOT_W     = $clog2(PIX_DEPTH + 1);
    localparam int CL_W      = $clog2(MAX_WIDTH + TAP_DEPTH) + 1;

    // Fixed widths of the data path.
    localparam int CNT_W  = 13;
    localparam int TAP_W  = 16;
    localparam int PIX_W  = 8;
    localparam int PROD_W = TAP_W + PIX_W;
    localparam int ACC_W  = PROD_W + $clog2(TAP_DEPTH);
    localparam int DVD_W  = 16;
    localparam int FRAC_W = 15;

    // Register map, by word index.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [6:0] RST_WIDTH  = 7'd24;
    localparam logic [6:0] RST_HEIGHT = 7'd24;
    localparam logic [4:0] RST_RADIUS = 5'd12;

    typedef enum logic [1:0] {
        FUNC_TAP   = 2'd0,
        FUNC_PIXEL = 2'd1,
        FUNC_FETCH = 2'd2
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [5:0]  tap_index;
        logic [15:0] tap_weight;
        logic [7:0]  pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       last_pixel;
    } out_word_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_DRAIN,
        ST_FRD,
        ST_FDIV,
        ST_FPUT
    } state_t;

endpackage

// ===== hw/rtl/rctn_ram.sv =====
// ----------------------------------------------------------------------------
// rctn_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rctn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rctn_mac.sv =====
// ----------------------------------------------------------------------------
// rctn_mac
// Shared multiply-accumulate unit. The product is registered before it is
// added, and the sum is rounded half up and saturated to eight bits.
// ----------------------------------------------------------------------------
module rctn_mac (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rctn_pkg::mac_ctl_t        ctl,
    input  logic [rctn_pkg::TAP_W-1:0] tap,
    input  logic [rctn_pkg::PIX_W-1:0] pix,
    output logic                      busy,
    output logic [rctn_pkg::PIX_W-1:0] sum_sat
);
    import rctn_pkg::*;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              pv_reg, pv_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W:0]    rounded;

    // Product stage and accumulator.
    always_comb begin
        prod_next = tap * pix;
        pv_next   = ctl.valid;
        acc_next  = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (pv_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= pv_next;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Round half up, then clip at full scale.
    assign rounded = ((ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(1 << (FRAC_W - 1))) >> FRAC_W;
    assign sum_sat = (rounded > (ACC_W + 1)'(8'hff)) ? 8'hff : rounded[PIX_W-1:0];
    assign busy    = pv_reg;

endmodule

// ===== hw/rtl/rctn_div.sv =====
// ----------------------------------------------------------------------------
// rctn_div
// Restoring divider, one quotient bit per cycle over the sixteen-bit dividend.
// ----------------------------------------------------------------------------
module rctn_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rctn_pkg::DVD_W-1:0]  dividend,
    input  logic [rctn_pkg::PIX_W-1:0]  divisor,
    output logic                        done,
    output logic [rctn_pkg::DVD_W-1:0]  quotient
);
    import rctn_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [PIX_W-1:0] rem_reg, rem_next;
    logic [PIX_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [PIX_W:0]   trial;
    logic             ge;

    // One shift-and-subtract step per cycle.
    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? PIX_W'(trial - {1'b0, dvs_reg}) : trial[PIX_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/row_convolve_transpose_normalize.sv =====
// ----------------------------------------------------------------------------
// row_convolve_transpose_normalize
// Loads kernel taps and an image, convolves each row through one shared
// multiply-accumulate unit, stores the result transposed and returns it
// scaled to the peak through a shared serial divider.
// ----------------------------------------------------------------------------
// Tap words and all but the last pixel word of an image leave ready high.
// The last pixel word of an image starts the convolution: width*height
// output pixels, each a sum over 2*radius+1 taps, all on the one MAC.
// A fetch word's result goes through the 16-step serial divider unless the peak is zero.
// Reset (aresetn low, synchronous) clears control state and restores the
// registers to 24, 24, 12; memories are not cleared.
module row_convolve_transpose_normalize (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rctn_pkg::in_word_t s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output rctn_pkg::out_word_t m_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rctn_pkg::*;

    state_t state_reg, state_next;

    logic [6:0] width_reg, height_reg;
    logic [4:0] radius_reg;

    logic [CNT_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]  fetch_cnt_reg, fetch_cnt_next;
    logic              ready_flag_reg, ready_flag_next;
    logic [PIX_W-1:0]  peak_reg, peak_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [Y_W-1:0]    y_reg, y_next;
    logic [TAP_AW-1:0] c_reg, c_next;
    logic [PIX_AW-1:0] row_base_reg, row_base_next;
    logic [PIX_AW-1:0] out_addr_reg, out_addr_next;
    logic              rv_reg, rv_next;
    logic              last_reg, last_next;
    logic [PIX_W-1:0]  res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;

    logic [EW_W-1:0]   w_eff;
    logic [EH_W-1:0]   h_eff;
    logic [R_W-1:0]    r_eff;
    logic [TOT_W-1:0]  total;
    logic [CNT_W-1:0]  lc_inc;

    logic s_acc, is_tap, is_pix, is_fetch;
    logic conv_start, fetch_ok, c_end, x_end, y_end, drained, out_free;
    logic cfg_wr;

    logic [CL_W-1:0]   xc_sum, ix;
    logic [PIX_AW-1:0] src_raddr;
    logic [TAP_W-1:0]  tap_rd;
    logic [PIX_W-1:0]  src_rd, filt_rd;
    logic              tap_we, src_we, filt_we;

    mac_ctl_t          mac_ctl;
    logic              mac_busy;
    logic [PIX_W-1:0]  mac_sum;
    logic              div_start, div_done;
    logic [DVD_W-1:0]  div_quo;

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            radius_reg <= RST_RADIUS;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[6:0];
                REG_HEIGHT: height_reg <= pwdata[6:0];
                REG_RADIUS: radius_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {25'd0, width_reg};
            REG_HEIGHT: prdata = {25'd0, height_reg};
            REG_RADIUS: prdata = {27'd0, radius_reg};
            default:    prdata = '0;
        endcase
    end

    // Effective image and kernel sizes.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = EW_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = EW_W'(MAX_WIDTH);
        end else begin
            w_eff = EW_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = EH_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = EH_W'(MAX_HEIGHT);
        end else begin
            h_eff = EH_W'(height_reg);
        end
        r_eff = (32'(radius_reg) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_reg);
        total = TOT_W'(w_eff * h_eff);
    end

    // Input decode.
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_acc      = s_valid && s_ready;
    assign is_tap     = s_acc && (s_word.func == FUNC_TAP);
    assign is_pix     = s_acc && (s_word.func == FUNC_PIXEL);
    assign is_fetch   = s_acc && (s_word.func == FUNC_FETCH);
    assign lc_inc     = load_cnt_reg + 1'b1;
    assign conv_start = is_pix && (32'(lc_inc) >= 32'(total));
    assign fetch_ok   = ready_flag_reg && (32'(fetch_cnt_reg) < 32'(total));

    // Convolution loop status.
    assign c_end    = (32'(c_reg) == 2 * 32'(r_eff));
    assign x_end    = (32'(x_reg) == 32'(w_eff) - 1);
    assign y_end    = (32'(y_reg) == 32'(h_eff) - 1);
    assign drained  = !rv_reg && !mac_busy;
    assign out_free = !out_valid_reg || m_ready;

    // Source column for the current tap, clamped to the row.
    always_comb begin
        xc_sum = CL_W'(x_reg) + CL_W'(c_reg);
        if (xc_sum < CL_W'(r_eff)) begin
            ix = '0;
        end else begin
            ix = xc_sum - CL_W'(r_eff);
        end
        if (ix > CL_W'(w_eff) - 1'b1) begin
            ix = CL_W'(w_eff) - 1'b1;
        end
        src_raddr = row_base_reg + PIX_AW'(ix);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (conv_start) begin
                    state_next = ST_CONV;
                end else if (is_fetch && fetch_ok) begin
                    state_next = ST_FRD;
                end
            end
            ST_CONV: begin
                if (c_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drained) begin
                    state_next = (x_end && y_end) ? ST_IDLE : ST_CONV;
                end
            end
            ST_FRD: begin
                state_next = (peak_reg == '0) ? ST_FPUT : ST_FDIV;
            end
            ST_FDIV: begin
                if (div_done) begin
                    state_next = ST_FPUT;
                end
            end
            ST_FPUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and counter updates.
    always_comb begin
        load_cnt_next   = load_cnt_reg;
        fetch_cnt_next  = fetch_cnt_reg;
        ready_flag_next = ready_flag_reg;
        peak_next       = peak_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        c_next          = c_reg;
        row_base_next   = row_base_reg;
        out_addr_next   = out_addr_reg;
        rv_next         = (state_reg == ST_CONV);
        last_next       = last_reg;
        res_next        = res_reg;
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        mac_ctl.valid   = rv_reg;
        mac_ctl.clear   = 1'b0;
        div_start       = 1'b0;
        filt_we         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                mac_ctl.clear = 1'b1;
                if (is_pix) begin
                    load_cnt_next = lc_inc;
                end
                if (conv_start) begin
                    load_cnt_next   = '0;
                    fetch_cnt_next  = '0;
                    ready_flag_next = 1'b1;
                    peak_next       = '0;
                    x_next          = '0;
                    y_next          = '0;
                    c_next          = '0;
                    row_base_next   = '0;
                    out_addr_next   = '0;
                end
                if (is_fetch) begin
                    if (fetch_ok) begin
                        last_next      = (CNT_W'(fetch_cnt_reg + 1'b1) == CNT_W'(total));
                        fetch_cnt_next = fetch_cnt_reg + 1'b1;
                        if (CNT_W'(fetch_cnt_reg + 1'b1) == CNT_W'(total)) begin
                            ready_flag_next = 1'b0;
                        end
                    end else begin
                        ready_flag_next = 1'b0;
                    end
                end
            end
            ST_CONV: begin
                c_next = c_reg + 1'b1;
            end
            ST_DRAIN: begin
                if (drained) begin
                    filt_we       = 1'b1;
                    mac_ctl.clear = 1'b1;
                    c_next        = '0;
                    if (mac_sum > peak_reg) begin
                        peak_next = mac_sum;
                    end
                    if (x_end) begin
                        x_next        = '0;
                        y_next        = y_reg + 1'b1;
                        row_base_next = row_base_reg + PIX_AW'(w_eff);
                        out_addr_next = PIX_AW'(y_reg) + 1'b1;
                    end else begin
                        x_next        = x_reg + 1'b1;
                        out_addr_next = out_addr_reg + PIX_AW'(h_eff);
                    end
                end
            end
            ST_FRD: begin
                if (peak_reg == '0) begin
                    res_next = '0;
                end else begin
                    div_start = 1'b1;
                end
            end
            ST_FDIV: begin
                if (div_done) begin
                    res_next = (div_quo > DVD_W'(8'hff)) ? 8'hff : div_quo[PIX_W-1:0];
                end
            end
            ST_FPUT: begin
                if (out_free) begin
                    out_valid_next           = 1'b1;
                    out_word_next.pixel_out  = res_reg;
                    out_word_next.last_pixel = last_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            load_cnt_reg   <= '0;
            fetch_cnt_reg  <= '0;
            ready_flag_reg <= 1'b0;
            peak_reg       <= '0;
            rv_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
            c_reg          <= '0;
        end else begin
            state_reg      <= state_next;
            load_cnt_reg   <= load_cnt_next;
            fetch_cnt_reg  <= fetch_cnt_next;
            ready_flag_reg <= ready_flag_next;
            peak_reg       <= peak_next;
            rv_reg         <= rv_next;
            out_valid_reg  <= out_valid_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            c_reg          <= c_next;
        end
        row_base_reg <= row_base_next;
        out_addr_reg <= out_addr_next;
        last_reg     <= last_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    // Memories.
    assign tap_we = is_tap && (32'(s_word.tap_index) < TAP_DEPTH);
    assign src_we = is_pix && (32'(load_cnt_reg) < PIX_DEPTH);

    rctn_ram #(.WIDTH(TAP_W), .DEPTH(TAP_DEPTH)) u_tap_ram (
        .aclk  (aclk),
        .we    (tap_we),
        .waddr (TAP_AW'(s_word.tap_index)),
        .wdata (s_word.tap_weight),
        .re    (state_reg == ST_CONV),
        .raddr (c_reg),
        .rdata (tap_rd)
    );

    rctn_ram #(.WIDTH(PIX_W), .DEPTH(PIX_DEPTH)) u_src_ram (
        .aclk  (aclk),
        .we    (src_we),
        .waddr (PIX_AW'(load_cnt_reg)),
        .wdata (s_word.pixel_in),
        .re    (state_reg == ST_CONV),
        .raddr (src_raddr),
        .rdata (src_rd)
    );

    rctn_ram #(.WIDTH(PIX_W), .DEPTH(PIX_DEPTH)) u_filt_ram (
        .aclk  (aclk),
        .we    (filt_we),
        .waddr (out_addr_reg),
        .wdata (mac_sum),
        .re    (is_fetch),
        .raddr (PIX_AW'(fetch_cnt_reg)),
        .rdata (filt_rd)
    );

    // Shared arithmetic units.
    rctn_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .tap     (tap_rd),
        .pix     (src_rd),
        .busy    (mac_busy),
        .sum_sat (mac_sum)
    );

    rctn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (DVD_W'({filt_rd, 8'h00}) - DVD_W'(filt_rd)),
        .divisor  (peak_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

endmodule

// ===== hw/rtl/rctn_checker.sv =====
// ----------------------------------------------------------------------------
// rctn_checker
// Port-level checks for the row convolution block, bound to the top level.
// ----------------------------------------------------------------------------
module rctn_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input rctn_pkg::in_word_t  s_word,
    input logic                m_valid,
    input logic                m_ready,
    input rctn_pkg::out_word_t m_word
);
    import rctn_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word present after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("stalled result word changed");

    // After a tap load, ready is high again in the next cycle.
    a_tap_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_word.func == FUNC_TAP |=> s_ready)
        else $error("tap load did not return ready");

    // A new result word only appears at the end of a busy fetch.
    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result word appeared while idle");

endmodule

bind row_convolve_transpose_normalize rctn_checker u_rctn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_word  (s_word),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
